>>> rtl/adjacency_matrix_graph_editor_assert.svh
// assertion macros shared by the checker
`ifndef ADJACENCY_MATRIX_GRAPH_EDITOR_ASSERT_SVH
`define ADJACENCY_MATRIX_GRAPH_EDITOR_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define AMGE_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication outside reset
`define AMGE_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

>>> rtl/amge_pkg.sv
// shared types and command codes of the graph editor
`default_nettype none
package amge_pkg;
    localparam int unsigned MAX_VERTICES = 32;
    localparam int unsigned CMD_W = 3;
    localparam int unsigned IDX_W = 5;
    localparam int unsigned ROW_W = 32;
    localparam int unsigned CNT_W = 6;
    localparam int unsigned IN_W = 56;
    localparam int unsigned OUT_W = 40;

    localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SETCNT   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_IDENTIFY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONTRACT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_SPLIT    = 3'd5;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_IDX = 2'd1;
    localparam logic [1:0] ST_NO_EDGE = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // datapath operations, one row per cycle for the sweeps
    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_WRITE,
        OP_SETCNT,
        OP_READ,
        OP_MERGE,
        OP_SPLIT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       sweep;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic       bad_idx;
        logic       no_edge;
        logic       full;
        logic       sweep_done;
    } t_status;
endpackage
`default_nettype wire

>>> rtl/amge_datapath.sv
// row storage, merge and split sweeps of the graph editor
`default_nettype none
module amge_datapath (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire amge_pkg::t_cmd             i_cmd,
    input  wire logic [amge_pkg::CMD_W-1:0] i_command,
    input  wire logic [amge_pkg::IDX_W-1:0] i_vertex_a,
    input  wire logic [amge_pkg::IDX_W-1:0] i_vertex_b,
    input  wire logic [amge_pkg::ROW_W-1:0] i_row_bits,
    input  wire logic [amge_pkg::CNT_W-1:0] i_new_count,
    output amge_pkg::t_status               o_status,
    output logic [amge_pkg::CNT_W-1:0]      o_count,
    output logic [amge_pkg::ROW_W-1:0]      o_row
);
    import amge_pkg::*;
    localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned CW = $clog2(MAX_VERTICES + 1);

    // rows of all vertices, reset to zero, one flop per bit
    logic [MAX_VERTICES-1:0] r_rows [MAX_VERTICES];
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_i;
    logic [CMD_W-1:0] r_cmd;
    logic [VW:0] r_a, r_lo, r_hi;
    logic [MAX_VERTICES-1:0] r_rowin, r_hirow, r_lorow, r_arow, r_loops, r_cmask;
    logic [CW-1:0] r_nc;
    logic r_edge;
    logic [ROW_W-1:0] r_rd;

    logic [VW:0] w_a, w_b;
    logic [VW:0] w_lo, w_hi;
    logic [MAX_VERTICES-1:0] w_cur, w_nxt, w_new, w_src, w_fold;
    logic [VW-1:0] w_i;

    function automatic logic [MAX_VERTICES-1:0] f_mask(input logic [CW-1:0] n);
        logic [MAX_VERTICES-1:0] m;
        for (int k = 0; k < MAX_VERTICES; k++) m[k] = (CW'(k) < n);
        return m;
    endfunction

    // remove bit k, shifting higher bits down
    function automatic logic [MAX_VERTICES-1:0] f_drop(input logic [MAX_VERTICES-1:0] r,
                                                        input logic [VW:0] k);
        logic [MAX_VERTICES-1:0] o;
        for (int j = 0; j < MAX_VERTICES; j++) begin
            if ((VW+1)'(j) < k) o[j] = r[j];
            else if (j + 1 < MAX_VERTICES) o[j] = r[j+1];
            else o[j] = 1'b0;
        end
        return o;
    endfunction

    assign w_a  = (VW+1)'(i_vertex_a);
    assign w_b  = (VW+1)'(i_vertex_b);
    assign w_lo = (w_a < w_b) ? w_a : w_b;
    assign w_hi = (w_a < w_b) ? w_b : w_a;
    assign w_i  = r_i[VW-1:0];
    assign w_cur = r_rows[w_i];
    assign w_nxt = (r_i + 1'b1 < CW'(MAX_VERTICES)) ? r_rows[VW'(r_i + 1'b1)] : '0;

    // row lo with row hi folded in
    always_comb begin
        w_fold = r_lorow | r_hirow;
        w_fold[r_lo[VW-1:0]] = r_lorow[r_lo[VW-1:0]];
        w_fold[r_hi[VW-1:0]] = r_lorow[r_hi[VW-1:0]];
    end

    // new value of row r_i during a sweep
    always_comb begin
        w_new = w_cur;
        w_src = '0;
        unique case (r_cmd)
            CMD_SETCNT: w_new = (r_i < r_nc) ? (w_cur & f_mask(r_nc)) : '0;
            CMD_IDENTIFY, CMD_CONTRACT: begin
                w_src = ({1'b0, w_i} >= r_hi) ? w_nxt : w_cur;
                if ({1'b0, w_i} == r_lo) w_src = r_lorow;
                if (w_src[r_hi[VW-1:0]]) w_src[r_lo[VW-1:0]] = 1'b1;
                w_src = f_drop(w_src, r_hi);
                if (r_i + 1'b1 >= r_cnt) w_src = '0;
                if (r_cmd == CMD_IDENTIFY) w_src[w_i] = ({1'b0, w_i} == r_lo) && r_edge;
                else w_src[w_i] = ({1'b0, w_i} != r_lo) && r_loops[w_i];
                w_new = w_src;
            end
            CMD_SPLIT: begin
                // new vertex copies row a, joined to a
                if (r_i == r_cnt)
                    w_new = (r_arow | (MAX_VERTICES'(1) << r_a[VW-1:0])) & r_cmask;
                else if (r_i < r_cnt && (w_cur[r_a[VW-1:0]] || {1'b0, w_i} == r_a))
                    w_new = w_cur | (MAX_VERTICES'(1) << r_cnt[VW-1:0]);
            end
            default: w_new = w_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_VERTICES; k++) r_rows[k] <= '0;
            r_cnt <= '0;
            r_i   <= '0;
        end else begin
            unique case (i_cmd.op)
                OP_LOAD: begin
                    r_cmd   <= i_command;
                    r_a     <= w_a;
                    r_lo    <= w_lo;
                    r_hi    <= w_hi;
                    r_rowin <= MAX_VERTICES'(i_row_bits);
                    r_nc    <= (i_new_count > CNT_W'(MAX_VERTICES)) ? '0 : CW'(i_new_count);
                    r_hirow <= r_rows[w_hi[VW-1:0]];
                    r_lorow <= r_rows[w_lo[VW-1:0]];
                    r_arow  <= r_rows[w_a[VW-1:0]];
                    r_cmask <= f_mask(r_cnt);
                    r_i     <= '0;
                    r_rd    <= '0;
                    for (int k = 0; k < MAX_VERTICES; k++) r_loops[k] <= r_rows[k][k];
                end
                OP_WRITE: r_rows[r_a[VW-1:0]] <= r_rowin & r_cmask;
                OP_READ:  r_rd <= ROW_W'(r_arow);
                OP_SETCNT, OP_MERGE, OP_SPLIT: begin
                    if (!i_cmd.sweep) begin
                        // fold row hi into lo before the shift sweep
                        r_edge  <= r_lorow[r_hi[VW-1:0]];
                        r_lorow <= w_fold;
                        r_loops <= f_drop(r_loops, r_hi);
                    end else begin
                        r_rows[w_i] <= w_new;
                        if (i_cmd.last) begin
                            if (i_cmd.op == OP_SETCNT) r_cnt <= r_nc;
                            else if (i_cmd.op == OP_MERGE) r_cnt <= r_cnt - 1'b1;
                            else r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_status.bad_idx = (r_cmd == CMD_WRITE || r_cmd == CMD_READ || r_cmd == CMD_SPLIT)
                              ? ({1'b0, r_a} >= (VW+2)'(r_cnt))
                              : ((r_cmd == CMD_IDENTIFY || r_cmd == CMD_CONTRACT) &&
                                 ({1'b0, r_hi} >= (VW+2)'(r_cnt) || r_lo == r_hi));
    assign o_status.no_edge = !r_lorow[r_hi[VW-1:0]];
    assign o_status.full    = (r_cnt >= CW'(MAX_VERTICES));
    assign o_status.sweep_done = (r_i == CW'(MAX_VERTICES - 1));
    assign o_count = CNT_W'(r_cnt);
    assign o_row   = r_rd;
endmodule
`default_nettype wire

>>> rtl/amge_ctrl.sv
// command sequencer of the graph editor
`default_nettype none
module amge_ctrl (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [amge_pkg::CMD_W-1:0] i_command,
    input  wire logic [amge_pkg::CNT_W-1:0] i_new_count,
    input  wire amge_pkg::t_status          i_status,
    output amge_pkg::t_cmd                  o_cmd,
    input  wire logic                       i_out_free,
    output logic                            o_done,
    output logic [1:0]                      o_code
);
    import amge_pkg::*;
    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_PREP, S_SWEEP, S_DONE} t_state;
    t_state r_state;
    logic [CMD_W-1:0] r_cmd;
    logic r_bad_cnt;
    logic [1:0] r_code;
    t_op w_op;

    always_comb begin
        unique case (r_cmd)
            CMD_WRITE: w_op = OP_WRITE;
            CMD_SETCNT: w_op = OP_SETCNT;
            CMD_READ: w_op = OP_READ;
            CMD_IDENTIFY, CMD_CONTRACT: w_op = OP_MERGE;
            CMD_SPLIT: w_op = OP_SPLIT;
            default: w_op = OP_NONE;
        endcase
    end

    always_comb begin
        o_cmd = '{op: OP_NONE, sweep: 1'b0, last: 1'b0};
        unique case (r_state)
            S_IDLE:  if (i_in_valid) o_cmd.op = OP_LOAD;
            S_PREP:  o_cmd = '{op: OP_MERGE, sweep: 1'b0, last: 1'b0};
            S_SWEEP: o_cmd = '{op: w_op, sweep: 1'b1,
                               last: i_status.sweep_done || w_op == OP_WRITE ||
                                     w_op == OP_READ || w_op == OP_NONE};
            default: ;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_done = (r_state == S_DONE);
    assign o_code = r_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_cmd     <= i_command;
                    r_bad_cnt <= (i_new_count > CNT_W'(MAX_VERTICES));
                    r_state   <= S_CHECK;
                end
                S_CHECK: begin
                    priority if (r_cmd == CMD_SETCNT && r_bad_cnt) begin
                        r_code <= ST_BAD_IDX; r_state <= S_DONE;
                    end else if (r_cmd != CMD_SETCNT && i_status.bad_idx) begin
                        r_code <= ST_BAD_IDX; r_state <= S_DONE;
                    end else if (r_cmd == CMD_CONTRACT && i_status.no_edge) begin
                        r_code <= ST_NO_EDGE; r_state <= S_DONE;
                    end else if (r_cmd == CMD_SPLIT && i_status.full) begin
                        r_code <= ST_FULL; r_state <= S_DONE;
                    end else if (r_cmd == CMD_IDENTIFY || r_cmd == CMD_CONTRACT) begin
                        r_code <= ST_OK; r_state <= S_PREP;
                    end else if (r_cmd > CMD_SPLIT) begin
                        r_code <= ST_OK; r_state <= S_DONE;
                    end else begin
                        r_code <= ST_OK; r_state <= S_SWEEP;
                    end
                end
                S_PREP:  r_state <= S_SWEEP;
                S_SWEEP: if (o_cmd.last) r_state <= S_DONE;
                S_DONE:  if (i_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/adjacency_matrix_graph_editor.sv
// Graph editor on a bit adjacency matrix of up to MAX_VERTICES vertices.
// One command word enters on the s_axis channel; exactly one result word
// leaves on m_axis for each accepted command.
// s_axis_tdata: command, vertex_a, vertex_b, row_bits, new_count (lowest first).
// m_axis_tdata: status, vertex_count, row_data (lowest first).
// After accept the sequencer checks the command; a failed check or an unused
// command code ends there, and write and read then do their one row access;
// set count and split sweep every row, one per cycle; identify and contract
// fold the two rows first and then sweep every row the same way.
// One command is handled at a time: s_axis_tready is high only while the
// sequencer idles, so the next command enters in the cycle after the result
// is registered at the earliest.
// While m_axis_tready is low the result waits in the output register; one more
// command may enter and run, and its result holds until the register frees.
// Reset clears every row and the vertex count and drops m_axis_tvalid.
`default_nettype none
module adjacency_matrix_graph_editor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // command[2:0], vertex_a[7:3], vertex_b[12:8], row_bits[44:13], new_count[50:45]
    input  wire logic [55:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], vertex_count[7:2], row_data[39:8]
    output logic [39:0]      m_axis_tdata
);
    import amge_pkg::*;
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready, w_done;
    logic [1:0] w_code;
    logic [CNT_W-1:0] w_count;
    logic [ROW_W-1:0] w_row;
    logic r_ovalid;
    logic [OUT_W-1:0] r_odata;
    logic w_free;

    assign w_free = !r_ovalid || m_axis_tready;

    amge_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(s_axis_tvalid), .o_in_ready(w_in_ready),
        .i_command(s_axis_tdata[2:0]), .i_new_count(s_axis_tdata[50:45]),
        .i_status(w_status), .o_cmd(w_cmd), .i_out_free(w_free),
        .o_done(w_done), .o_code(w_code)
    );

    amge_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_command(s_axis_tdata[2:0]), .i_vertex_a(s_axis_tdata[7:3]),
        .i_vertex_b(s_axis_tdata[12:8]), .i_row_bits(s_axis_tdata[44:13]),
        .i_new_count(s_axis_tdata[50:45]),
        .o_status(w_status), .o_count(w_count), .o_row(w_row)
    );

    assign s_axis_tready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else begin
            if (w_done && w_free) begin
                r_ovalid <= 1'b1;
                r_odata  <= {(w_code == ST_OK) ? w_row : ROW_W'(0), w_count, w_code};
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
endmodule
`default_nettype wire

>>> rtl/amge_checker.sv
// port-level checks of the graph editor
`default_nettype none
`include "adjacency_matrix_graph_editor_assert.svh"
module amge_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [39:0] m_axis_tdata
);
    import amge_pkg::*;
    logic w_stall, w_accept, w_error;
    logic [CNT_W-1:0] w_count;
    logic [ROW_W-1:0] w_row;

    assign w_stall  = m_axis_tvalid && !m_axis_tready;
    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_error  = m_axis_tvalid && (m_axis_tdata[1:0] != ST_OK);
    assign w_count  = m_axis_tdata[7:2];
    assign w_row    = m_axis_tdata[39:8];

    `AMGE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, m_axis_tvalid && $stable(m_axis_tdata))
    `AMGE_ASSERT_IMP(a_count_range, i_clk, i_rst_n, m_axis_tvalid, w_count <= CNT_W'(MAX_VERTICES))
    `AMGE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !s_axis_tready)
    `AMGE_ASSERT_IMP(a_row_zero_on_error, i_clk, i_rst_n, w_error, w_row == '0)
endmodule
bind adjacency_matrix_graph_editor amge_checker u_amge_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

>>> tb/graph_editor_checker.sv
// checker for the graph editor: predicts each result word and compares it
module graph_editor_checker
    import amge_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [55:0] i_cmd_data,  // command, vertex_a, vertex_b, row_bits, new_count
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [39:0] i_res_data,  // status, vertex_count, row_data
    output int          o_fail_count,
    output int          o_pending,
    output int          o_vertex_total
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VMAX = 32;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  count;
        logic [31:0] row;
    } t_outcome;

    logic [31:0] graph_rows [VMAX];
    int          graph_size;
    t_outcome    outcome_q [$];
    int          fails;

    assign o_fail_count   = fails;
    assign o_pending      = outcome_q.size();
    assign o_vertex_total = graph_size;

    function automatic logic [31:0] width_mask(int n);
        return n >= 32 ? 32'hFFFF_FFFF : 32'((64'd1 << n) - 1);
    endfunction

    // remove bit k and pull the higher bits down by one
    function automatic logic [31:0] squeeze_out(logic [31:0] r, int k);
        logic [63:0] w;
        w = {32'd0, r};
        return 32'((w & ((64'd1 << k) - 1)) | ((w >> (k + 1)) << k));
    endfunction

    task automatic remove_vertex(int v);
        int n;
        n = graph_size;
        for (int i = v; i + 1 < n; i++) graph_rows[i] = graph_rows[i + 1];
        graph_rows[n - 1] = '0;
        for (int i = 0; i + 1 < n; i++) graph_rows[i] = squeeze_out(graph_rows[i], v);
        graph_size = n - 1;
    endtask

    task automatic apply_command(input logic [55:0] word, output t_outcome res);
        logic [2:0]  cmd;
        int          a, b, nc, n, lo, hi;
        logic [31:0] row_in, rd, loops, nr;
        logic        edge_seen;
        logic [1:0]  st;
        cmd    = word[2:0];
        a      = word[7:3];
        b      = word[12:8];
        row_in = word[44:13];
        nc     = word[50:45];
        n      = graph_size;
        st     = ST_OK;
        rd     = '0;
        lo     = a < b ? a : b;
        hi     = a < b ? b : a;
        case (cmd)
            CMD_WRITE: begin
                if (a >= n) st = ST_BAD_IDX;
                else graph_rows[a] = row_in & width_mask(n);
            end
            CMD_SETCNT: begin
                if (nc > VMAX) st = ST_BAD_IDX;
                else begin
                    for (int i = 0; i < VMAX; i++)
                        graph_rows[i] = i >= nc ? '0 : graph_rows[i] & width_mask(nc);
                    graph_size = nc;
                end
            end
            CMD_READ: begin
                if (a >= n) st = ST_BAD_IDX;
                else rd = graph_rows[a];
            end
            CMD_IDENTIFY, CMD_CONTRACT: begin
                if (a >= n || b >= n || a == b) st = ST_BAD_IDX;
                else if (cmd == CMD_IDENTIFY) begin
                    edge_seen = graph_rows[lo][hi];
                    for (int i = 0; i < n; i++) begin
                        if (i != lo && i != hi) begin
                            if (graph_rows[hi][i]) graph_rows[lo][i] = 1'b1;
                            if (graph_rows[i][hi]) graph_rows[i][lo] = 1'b1;
                        end
                    end
                    remove_vertex(hi);
                    for (int i = 0; i < graph_size; i++) graph_rows[i][i] = 1'b0;
                    if (edge_seen) graph_rows[lo][lo] = 1'b1;
                end else if (!graph_rows[lo][hi]) begin
                    st = ST_NO_EDGE;
                end else begin
                    loops = '0;
                    for (int i = 0; i < n; i++) loops[i] = graph_rows[i][i];
                    for (int i = 0; i < n; i++)
                        if (graph_rows[i][hi]) graph_rows[i][lo] = 1'b1;
                    graph_rows[lo] |= graph_rows[hi];
                    remove_vertex(hi);
                    loops = squeeze_out(loops, hi);
                    for (int i = 0; i < graph_size; i++)
                        graph_rows[i][i] = (i != lo) && loops[i];
                end
            end
            CMD_SPLIT: begin
                if (a >= n) st = ST_BAD_IDX;
                else if (n >= VMAX) st = ST_FULL;
                else begin
                    nr = graph_rows[a];
                    nr[a] = 1'b1;
                    for (int i = 0; i < n; i++)
                        if (graph_rows[i][a]) graph_rows[i][n] = 1'b1;
                    graph_rows[a][n] = 1'b1;
                    graph_rows[n] = nr & width_mask(n);
                    graph_size = n + 1;
                end
            end
            default: ;  // unused codes leave everything alone
        endcase
        res.status = st;
        res.count  = 6'(graph_size);
        res.row    = rd;
    endtask

    task automatic report(string what, logic [39:0] got, logic [39:0] want);
        $display("checker: %s got %h want %h at %0t", what, got, want, $realtime);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_outcome res, want;
        if (!i_rst_n) begin
            for (int i = 0; i < VMAX; i++) graph_rows[i] = '0;
            graph_size = 0;
            outcome_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (outcome_q.size() == 0) begin
                    report("unexpected word", i_res_data, '0);
                end else begin
                    want = outcome_q.pop_front();
                    if (i_res_data[1:0] != want.status)
                        report("status", i_res_data, want);
                    if (i_res_data[7:2] != want.count)
                        report("vertex_count", i_res_data, want);
                    if (i_res_data[39:8] != want.row)
                        report("row_data", i_res_data, want);
                end
            end
            if (i_cmd_valid && i_cmd_ready) begin
                apply_command(i_cmd_data, res);
                outcome_q.push_back(res);
            end
        end
    end

    initial fails = 0;
endmodule

>>> tb/testbench.sv
// stimulus and verdict for the graph editor
module testbench;
    import amge_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    int          fail_count, pending, vertex_total;
    int          send_idle = 7, recv_idle = 60;
    bit          hold_request = 1'b0;
    int          cycles = 0;

    adjacency_matrix_graph_editor dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata)
    );

    graph_editor_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(s_tvalid), .i_cmd_ready(s_tready), .i_cmd_data(s_tdata),
        .i_res_valid(m_tvalid), .i_res_ready(m_tready), .i_res_data(m_tdata),
        .o_fail_count(fail_count), .o_pending(pending), .o_vertex_total(vertex_total)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("adjacency_matrix_graph_editor: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_request) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_request = 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
                @(posedge i_clk);
            end
        end
    end

    task automatic send_word(logic [2:0] cmd, int a, int b, logic [31:0] row, int nc);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, 6'(nc), row, 5'(b), 5'(a), cmd};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly in-range indices so that merges and splits really happen
    function automatic int pick_vertex();
        if (vertex_total > 0 && $urandom_range(0, 99) < 88)
            return $urandom_range(0, vertex_total - 1);
        return $urandom_range(0, 31);
    endfunction

    task automatic send_random;
        int          roll, nc;
        logic [2:0]  cmd;
        logic [31:0] row;
        roll = $urandom_range(0, 99);
        row  = $urandom();
        if ($urandom_range(0, 3) == 0) row = row | $urandom();
        nc   = $urandom_range(2, 32);
        if (roll < 20)      cmd = CMD_WRITE;
        else if (roll < 38) cmd = CMD_READ;
        else if (roll < 50) cmd = CMD_IDENTIFY;
        else if (roll < 66) cmd = CMD_CONTRACT;
        else if (roll < 84) cmd = CMD_SPLIT;
        else if (roll < 97) begin
            cmd = CMD_SETCNT;
            if ($urandom_range(0, 4) == 0) nc = $urandom_range(0, 63);
        end else begin
            cmd = 3'($urandom_range(6, 7));
        end
        send_word(cmd, pick_vertex(), pick_vertex(), row, nc);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty graph, count limits, row extremes, every command
        send_word(CMD_READ, 0, 0, '0, 0);
        send_word(CMD_WRITE, 0, 0, '1, 0);
        send_word(CMD_SETCNT, 0, 0, '0, 33);
        send_word(CMD_SETCNT, 0, 0, '0, 63);
        send_word(CMD_SETCNT, 0, 0, '0, 32);
        send_word(CMD_WRITE, 31, 0, '1, 0);
        send_word(CMD_WRITE, 0, 0, 32'h8000_0001, 0);
        send_word(CMD_READ, 31, 0, '0, 0);
        send_word(CMD_SPLIT, 0, 0, '0, 0);
        send_word(CMD_IDENTIFY, 0, 31, '0, 0);
        send_word(CMD_CONTRACT, 3, 3, '0, 0);
        send_word(CMD_CONTRACT, 3, 5, '0, 0);
        send_word(CMD_CONTRACT, 30, 0, '0, 0);
        send_word(CMD_WRITE, 1, 0, 32'hAAAA_5555, 0);
        send_word(CMD_SETCNT, 0, 0, '0, 4);
        send_word(CMD_READ, 1, 0, '0, 0);
        send_word(CMD_READ, 4, 0, '0, 0);
        send_word(CMD_WRITE, 2, 0, '1, 0);
        send_word(CMD_SPLIT, 2, 0, '0, 0);
        send_word(CMD_SPLIT, 9, 0, '0, 0);
        send_word(CMD_IDENTIFY, 2, 1, '0, 0);
        send_word(3'd6, 1, 1, '1, 63);
        send_word(3'd7, 0, 0, '0, 0);
        send_word(CMD_SETCNT, 0, 0, '0, 1);
        send_word(CMD_SETCNT, 0, 0, '0, 0);
        drain();

        send_word(CMD_SETCNT, 0, 0, '0, 12);
        for (int k = 0; k < 1230; k++) begin
            if (k == 410) begin
                send_idle = 60;
                recv_idle = 7;
            end
            if (k == 820) begin
                send_idle = 0;
                recv_idle = 0;
                hold_request = 1'b1;  // receiver backs off while words keep coming
            end
            if (k == 600) drain();
            send_random();
        end
        drain();
        repeat (60) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("adjacency_matrix_graph_editor: match");
        end else begin
            $display("adjacency_matrix_graph_editor: mismatch");
        end
        $finish;
    end
endmodule
